// ----- src/q2e_pkg.sv -----
// Shared constants, CORDIC angle table and pipeline sideband types for quaternion_to_euler.
package q2e_pkg;

    localparam int QUAT_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    // datapath widths: Q28 vectors with CORDIC growth, Q30 angle accumulator, root radicand
    localparam int DW           = 38;
    localparam int ZW           = 36;
    localparam int SQ_W         = 58;
    localparam int SQ_STEPS     = 29;
    localparam int CORDIC_STEPS = 30;

    localparam longint ONE_Q28     = 64'sd268435456;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // round(atan(2^-i) * 2^30)
    function automatic longint atan_q30(input int i);
        longint t;
        unique case (i)
            0:       t = 843314857;
            1:       t = 497837829;
            2:       t = 263043837;
            3:       t = 133525159;
            4:       t = 67021687;
            5:       t = 33543516;
            6:       t = 16775851;
            7:       t = 8388437;
            8:       t = 4194283;
            9:       t = 2097149;
            default: t = longint'(64'sd1 <<< (30 - i));
        endcase
        return t;
    endfunction

    // vectors and asin argument riding along the root chain
    typedef struct packed {
        logic signed [DW-1:0] y0;
        logic signed [DW-1:0] x0;
        logic signed [DW-1:0] y1;
        logic signed [DW-1:0] x1;
        logic signed [DW-1:0] s;
        logic                 clamped;
    } side_t;

    // flags riding along the CORDIC chains
    typedef struct packed {
        logic [2:0] zero;
        logic       clamped;
    } flag_t;

endpackage

// ----- src/quaternion_to_euler.sv -----
// Quaternion to Euler angles: product stage, root cell chain, three CORDIC cell chains.
// One beat per cycle sustained while the output side keeps taking beats.
// Stages: products, sums and clamp, square, radicand, 29 root cells, CORDIC prep,
// 30 CORDIC cells per angle, rounding. The whole pipe holds while the output beat waits.
// Reset (rst_n, asynchronous, active low) clears the valid line; data regs are not reset.
module quaternion_to_euler #(
    parameter int QUAT_WIDTH  = q2e_pkg::QUAT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = q2e_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0] angle_x,
    output logic signed [ANGLE_WIDTH-1:0] angle_y,
    output logic signed [ANGLE_WIDTH-2:0] angle_z,
    output logic                          asin_clamped
);

    localparam int DW   = q2e_pkg::DW;
    localparam int ZW   = q2e_pkg::ZW;
    localparam int SQW  = q2e_pkg::SQ_W;
    localparam int NS   = q2e_pkg::SQ_STEPS;
    localparam int NC   = q2e_pkg::CORDIC_STEPS;
    localparam int PW   = 2 * QUAT_WIDTH;
    localparam int SH   = 2 * (QUAT_WIDTH - 2) - 29;
    localparam int NPIPE = 4 + NS + 1 + NC + 1;
    localparam int OSH  = 33 - ANGLE_WIDTH;
    localparam longint LIM_XY = (q2e_pkg::PI_Q30 + (64'sd1 <<< (OSH - 1))) >>> OSH;
    localparam longint LIM_Z  = (q2e_pkg::HALF_PI_Q30 + (64'sd1 <<< (OSH - 1))) >>> OSH;
    localparam logic signed [DW-1:0] ONE   = DW'(q2e_pkg::ONE_Q28);
    localparam logic [SQW-1:0]       ONE_SQ = SQW'(1) << 56;

    logic en;
    logic [NPIPE-1:0] valid_reg;

    // pipe advances whenever the output slot is free or being taken
    assign en       = !valid_reg[NPIPE-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NPIPE-2:0], in_valid};
    end

    function automatic logic signed [DW-1:0] to_q28(input logic signed [PW-1:0] p);
        logic signed [63:0] e;
        e = 64'(p);
        if (SH >= 0)
            e = e >>> SH;
        else
            e = e <<< (-SH);
        return e[DW-1:0];
    endfunction

    // stage A: doubled products in Q28
    logic signed [DW-1:0] xy_reg, xz_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [DW-1:0] xw_reg, yw_reg, zw_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_reg <= to_q28(PW'(quat_x * quat_y));
            xz_reg <= to_q28(PW'(quat_x * quat_z));
            yz_reg <= to_q28(PW'(quat_y * quat_z));
            xx_reg <= to_q28(PW'(quat_x * quat_x));
            yy_reg <= to_q28(PW'(quat_y * quat_y));
            zz_reg <= to_q28(PW'(quat_z * quat_z));
            xw_reg <= to_q28(PW'(quat_x * quat_w));
            yw_reg <= to_q28(PW'(quat_y * quat_w));
            zw_reg <= to_q28(PW'(quat_z * quat_w));
        end
    end

    // stage B: atan2 operands and clamped asin argument
    q2e_pkg::side_t side_next;
    q2e_pkg::side_t side_reg [0:NS+2];
    logic signed [DW-1:0] s_raw;

    always_comb
    begin
        s_raw        = xy_reg + zw_reg;
        side_next.y0 = xw_reg - yz_reg;
        side_next.x0 = ONE - xx_reg - zz_reg;
        side_next.y1 = yw_reg - xz_reg;
        side_next.x1 = ONE - yy_reg - zz_reg;
        side_next.clamped = 1'b0;
        side_next.s  = s_raw;
        if (s_raw > ONE)
        begin
            side_next.s = ONE;
            side_next.clamped = 1'b1;
        end
        else if (s_raw < -ONE)
        begin
            side_next.s = -ONE;
            side_next.clamped = 1'b1;
        end
    end

    // sideband delay line through square, radicand and root stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= NS + 2; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // stages C and D: s squared, then radicand 2^56 - s^2
    logic signed [29:0]     s_narrow;
    logic signed [59:0]     ss_full;
    logic [SQW-1:0]         ss_reg, rad_reg;

    assign s_narrow = side_reg[0].s[29:0];
    assign ss_full  = s_narrow * s_narrow;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg  <= SQW'(ss_full);
            rad_reg <= ONE_SQ - ss_reg;
        end
    end

    // root cell chain
    logic [SQW-1:0] sq_v [0:NS];
    logic [SQW-1:0] sq_r [0:NS];

    assign sq_v[0] = rad_reg;
    assign sq_r[0] = '0;

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.STEP(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .v_in  (sq_v[k]),
            .r_in  (sq_r[k]),
            .v_out (sq_v[k+1]),
            .r_out (sq_r[k+1])
        );
    end

    // CORDIC prep: zero check, half-plane fold
    logic signed [DW-1:0] py [0:2];
    logic signed [DW-1:0] px [0:2];
    logic signed [DW-1:0] cx [0:2][0:NC];
    logic signed [DW-1:0] cy [0:2][0:NC];
    logic signed [ZW-1:0] cz [0:2][0:NC];
    logic signed [DW-1:0] pre_x_reg [0:2];
    logic signed [DW-1:0] pre_y_reg [0:2];
    logic signed [ZW-1:0] pre_z_reg [0:2];
    q2e_pkg::flag_t flag_reg [0:NC+1];
    q2e_pkg::flag_t flag_next;

    assign py[0] = side_reg[NS+2].y0;
    assign px[0] = side_reg[NS+2].x0;
    assign py[1] = side_reg[NS+2].y1;
    assign px[1] = side_reg[NS+2].x1;
    assign py[2] = side_reg[NS+2].s;
    assign px[2] = DW'(sq_r[NS]);

    always_comb
    begin
        flag_next.clamped = side_reg[NS+2].clamped;
        for (int c = 0; c < 3; c++)
            flag_next.zero[c] = (px[c] == '0) && (py[c] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (px[c][DW-1])
                begin
                    pre_x_reg[c] <= -px[c];
                    pre_y_reg[c] <= -py[c];
                    pre_z_reg[c] <= py[c][DW-1] ? -ZW'(q2e_pkg::PI_Q30) : ZW'(q2e_pkg::PI_Q30);
                end
                else
                begin
                    pre_x_reg[c] <= px[c];
                    pre_y_reg[c] <= py[c];
                    pre_z_reg[c] <= '0;
                end
            end
            flag_reg[0] <= flag_next;
            for (int k = 1; k <= NC + 1; k++)
                flag_reg[k] <= flag_reg[k-1];
        end
    end

    // three CORDIC cell chains
    for (genvar c = 0; c < 3; c++)
    begin : g_chain
        assign cx[c][0] = pre_x_reg[c];
        assign cy[c][0] = pre_y_reg[c];
        assign cz[c][0] = pre_z_reg[c];
        for (genvar k = 0; k < NC; k++)
        begin : g_cell
            q2e_cordic_cell #(.STEP(k)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[c][k]),
                .y_in  (cy[c][k]),
                .z_in  (cz[c][k]),
                .x_out (cx[c][k+1]),
                .y_out (cy[c][k+1]),
                .z_out (cz[c][k+1])
            );
        end
    end

    // output stage: round half up, saturate, zero angle for a zero vector
    function automatic logic signed [ZW-1:0] round_sat(input logic signed [ZW-1:0] z,
                                                       input logic signed [ZW-1:0] lim,
                                                       input logic zero);
        logic signed [ZW-1:0] r;
        r = (z + (ZW'(1) <<< (OSH - 1))) >>> OSH;
        if (zero)
            r = '0;
        else if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r;
    endfunction

    logic signed [ZW-1:0] ox, oy, oz;
    logic signed [ANGLE_WIDTH-1:0] angle_x_reg, angle_y_reg;
    logic signed [ANGLE_WIDTH-2:0] angle_z_reg;
    logic                          clamped_reg;

    assign ox = round_sat(cz[0][NC], ZW'(LIM_XY), flag_reg[NC].zero[0]);
    assign oy = round_sat(cz[1][NC], ZW'(LIM_XY), flag_reg[NC].zero[1]);
    assign oz = round_sat(cz[2][NC], ZW'(LIM_Z),  flag_reg[NC].zero[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_x_reg <= ox[ANGLE_WIDTH-1:0];
            angle_y_reg <= oy[ANGLE_WIDTH-1:0];
            angle_z_reg <= oz[ANGLE_WIDTH-2:0];
            clamped_reg <= flag_reg[NC].clamped;
        end
    end

    assign out_valid    = valid_reg[NPIPE-1];
    assign angle_x      = angle_x_reg;
    assign angle_y      = angle_y_reg;
    assign angle_z      = angle_z_reg;
    assign asin_clamped = clamped_reg;

`ifndef SYNTHESIS
    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted beat lost at pipe entry");

    // a waiting result beat holds angle_x and angle_z
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(angle_x) && $stable(angle_z)))
        else $error("result beat changed while stalled");

    // saturation keeps angle_x within +-pi
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (($signed(angle_x) <= $signed(ZW'(LIM_XY))) &&
                       ($signed(angle_x) >= -$signed(ZW'(LIM_XY)))))
        else $error("angle_x beyond saturation limit");
`endif

endmodule

// ----- src/q2e_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root.
module q2e_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [q2e_pkg::SQ_W-1:0]   v_in,
    input  logic [q2e_pkg::SQ_W-1:0]   r_in,
    output logic [q2e_pkg::SQ_W-1:0]   v_out,
    output logic [q2e_pkg::SQ_W-1:0]   r_out
);

    localparam logic [q2e_pkg::SQ_W-1:0] BIT =
        q2e_pkg::SQ_W'(1) << (2 * (q2e_pkg::SQ_STEPS - 1 - STEP));

    logic [q2e_pkg::SQ_W-1:0] v_reg, r_reg, v_next, r_next, trial;

    // restoring digit step
    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

// ----- src/q2e_cordic_cell.sv -----
// One vectoring micro-rotation cell of a CORDIC atan2 chain.
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [q2e_pkg::DW-1:0]   x_in,
    input  logic signed [q2e_pkg::DW-1:0]   y_in,
    input  logic signed [q2e_pkg::ZW-1:0]   z_in,
    output logic signed [q2e_pkg::DW-1:0]   x_out,
    output logic signed [q2e_pkg::DW-1:0]   y_out,
    output logic signed [q2e_pkg::ZW-1:0]   z_out
);

    localparam logic signed [q2e_pkg::ZW-1:0] T =
        q2e_pkg::ZW'(q2e_pkg::atan_q30(STEP));

    logic signed [q2e_pkg::DW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [q2e_pkg::ZW-1:0] z_reg, z_next;

    // rotate toward the x axis
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[q2e_pkg::DW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + T;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - T;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
